### src/gfmac_pkg.sv
// Shared types, constants and GF(2^128) helper functions for the multiply-accumulate block.
`default_nettype none

package gfmac_pkg;

   localparam int PARTIES    = 16;
   localparam int PARTY_W    = (PARTIES > 1) ? $clog2(PARTIES) : 1;
   localparam int PARTY_IN_W = 4;
   localparam int HALF_W     = 64;
   localparam int FIELD_W    = 2 * HALF_W;
   localparam int SLICE_W    = 32;
   localparam int SLICES     = FIELD_W / SLICE_W;
   localparam int SPROD_W    = FIELD_W + SLICE_W - 1;
   localparam int PROD_W     = 2 * FIELD_W - 1;
   localparam int TAIL_W     = 8;
   localparam int FOLD_W     = HALF_W + TAIL_W - 1;
   localparam logic [TAIL_W-1:0] POLY_TAIL = 8'h87;
   // Accept to result strobe: multiplier slices, reduction, response register.
   localparam int LATENCY    = SLICES + 2;

   typedef enum logic {
      CMD_MAC  = 1'b0,
      CMD_LOAD = 1'b1
   } cmd_type;

   typedef struct packed {
      logic               vld;
      cmd_type            cmd;
      logic [PARTY_W-1:0] idx;
   } ctl_type;

   // Party number folded into the accumulator range by repeated subtraction.
   function automatic logic [PARTY_W-1:0] wrap_party(input logic [PARTY_IN_W-1:0] p);
      logic [PARTY_IN_W-1:0] v;
      v = p;
      for (int i = 0; i < 8; i++) begin
         if (int'(v) >= PARTIES) begin
            v = v - PARTY_IN_W'(PARTIES);
         end
      end
      return PARTY_W'(v);
   endfunction

   // Carry-less product of the full operand with one multiplier slice.
   function automatic logic [SPROD_W-1:0] clmul_slice(input logic [FIELD_W-1:0] a,
                                                      input logic [SLICE_W-1:0] m);
      logic [SPROD_W-1:0] r;
      r = '0;
      for (int i = 0; i < SLICE_W; i++) begin
         if (m[i]) begin
            r = r ^ (SPROD_W'(a) << i);
         end
      end
      return r;
   endfunction

   // Carry-less product of a 64-bit word with the low tail of the field polynomial.
   function automatic logic [FOLD_W-1:0] fold_tail(input logic [HALF_W-1:0] a);
      logic [FOLD_W-1:0] r;
      r = '0;
      for (int i = 0; i < TAIL_W; i++) begin
         if (POLY_TAIL[i]) begin
            r = r ^ (FOLD_W'(a) << i);
         end
      end
      return r;
   endfunction

   // Reduction modulo x^128 + x^7 + x^2 + x + 1, top word folded first.
   function automatic logic [FIELD_W-1:0] gf_reduce(input logic [PROD_W-1:0] p);
      logic [2*FIELD_W-1:0] w;
      logic [HALF_W-1:0]    p0;
      logic [HALF_W-1:0]    p1;
      logic [HALF_W-1:0]    p2;
      logic [HALF_W-1:0]    p3;
      logic [FOLD_W-1:0]    f;
      w  = {1'b0, p};
      p0 = w[0 +: HALF_W];
      p1 = w[HALF_W +: HALF_W];
      p2 = w[2*HALF_W +: HALF_W];
      p3 = w[3*HALF_W +: HALF_W];
      f  = fold_tail(p3);
      p1 = p1 ^ f[HALF_W-1:0];
      p2 = p2 ^ HALF_W'(f[FOLD_W-1:HALF_W]);
      f  = fold_tail(p2);
      p0 = p0 ^ f[HALF_W-1:0];
      p1 = p1 ^ HALF_W'(f[FOLD_W-1:HALF_W]);
      return {p1, p0};
   endfunction

endpackage

`default_nettype wire

### src/gfmac_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
`default_nettype none

module gfmac_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 16,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // A read of the entry being written returns the old contents.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### src/gfmac_mul_pipe.sv
// Pipelined carry-less 128x128 multiplier, one 32-bit multiplier slice per stage, then reduction.
`default_nettype none

module gfmac_mul_pipe (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire gfmac_pkg::ctl_type               in_ctl,
   input  wire logic [gfmac_pkg::FIELD_W-1:0]    in_op,
   input  wire logic [gfmac_pkg::FIELD_W-1:0]    in_mult,
   output gfmac_pkg::ctl_type                    rd_ctl,
   output gfmac_pkg::ctl_type                    red_ctl,
   output logic      [gfmac_pkg::FIELD_W-1:0]    red_op,
   output logic      [gfmac_pkg::FIELD_W-1:0]    red_prod
);

   import gfmac_pkg::*;

   ctl_type            ctl_ff  [SLICES];
   ctl_type            ctl_in  [SLICES];
   logic [FIELD_W-1:0] op_ff   [SLICES];
   logic [FIELD_W-1:0] op_in   [SLICES];
   logic [FIELD_W-1:0] mult_ff [SLICES-1];
   logic [FIELD_W-1:0] mult_in [SLICES-1];
   logic [PROD_W-1:0]  prod_ff [SLICES];
   logic [PROD_W-1:0]  prod_in [SLICES];

   ctl_type            red_ctl_ff;
   logic [FIELD_W-1:0] red_op_ff;
   logic [FIELD_W-1:0] red_prod_ff;

   // Stage k adds the partial product of the operand with multiplier slice k.
   assign ctl_in[0]  = in_ctl;
   assign op_in[0]   = in_op;
   assign mult_in[0] = in_mult;
   assign prod_in[0] = PROD_W'(clmul_slice(in_op, in_mult[0 +: SLICE_W]));

   for (genvar k = 1; k < SLICES; k++) begin : g_stage
      assign ctl_in[k]  = ctl_ff[k-1];
      assign op_in[k]   = op_ff[k-1];
      assign prod_in[k] = prod_ff[k-1]
                        ^ (PROD_W'(clmul_slice(op_ff[k-1], mult_ff[k-1][k*SLICE_W +: SLICE_W]))
                           << (k * SLICE_W));
      if (k < SLICES - 1) begin : g_mult
         assign mult_in[k] = mult_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < SLICES; k++) begin
            ctl_ff[k].vld <= 1'b0;
         end
         red_ctl_ff.vld <= 1'b0;
      end else begin
         for (int k = 0; k < SLICES; k++) begin
            ctl_ff[k] <= ctl_in[k];
         end
         red_ctl_ff <= ctl_ff[SLICES-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < SLICES; k++) begin
         op_ff[k]   <= op_in[k];
         prod_ff[k] <= prod_in[k];
      end
      for (int k = 0; k < SLICES - 1; k++) begin
         mult_ff[k] <= mult_in[k];
      end
      red_op_ff   <= op_ff[SLICES-1];
      red_prod_ff <= gf_reduce(prod_ff[SLICES-1]);
   end

   assign rd_ctl   = ctl_ff[SLICES-1];
   assign red_ctl  = red_ctl_ff;
   assign red_op   = red_op_ff;
   assign red_prod = red_prod_ff;

endmodule

`default_nettype wire

### src/gf128_multiply_accumulate.sv
// GF(2^128) multiply-accumulate block: one accumulator per party, kept in RAM.
//
// Request channel: a transaction is taken at a rising edge with start high and busy
// low. It names a party, a 128-bit operand and a 128-bit multiplier. Command MAC
// XORs the reduced carry-less product into the party's accumulator; command LOAD
// writes the operand into it. busy is high only while reset is asserted, so a new
// transaction may be issued in every cycle.
// Response channel: every transaction returns the party and its updated accumulator,
// shown for one cycle with rsp_strobe high, after four stages of 128x32 carry-less
// multiplication, one reduction stage that also reads the accumulator RAM and one
// response register. Throughput is one transaction per cycle.
// The receiver cannot stall the block; responses leave in request order.
// Back-to-back transactions to the same party are served by forwarding the value
// being written into the RAM at the time of the read.
// Reset clears the pipeline and the per-party valid bits; an accumulator that has
// not been written since reset reads as zero, so no clearing pass is needed.
`default_nettype none

module gf128_multiply_accumulate (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                start,
   output logic                                     busy,
   input  wire logic                                req_command,
   input  wire logic [gfmac_pkg::PARTY_IN_W-1:0]    req_party,
   input  wire logic [gfmac_pkg::HALF_W-1:0]        req_operand_low,
   input  wire logic [gfmac_pkg::HALF_W-1:0]        req_operand_high,
   input  wire logic [gfmac_pkg::HALF_W-1:0]        req_mult_low,
   input  wire logic [gfmac_pkg::HALF_W-1:0]        req_mult_high,
   output logic                                     rsp_strobe,
   output logic      [gfmac_pkg::PARTY_IN_W-1:0]    rsp_out_party,
   output logic      [gfmac_pkg::HALF_W-1:0]        rsp_acc_out_low,
   output logic      [gfmac_pkg::HALF_W-1:0]        rsp_acc_out_high
);

   import gfmac_pkg::*;

   ctl_type            in_ctl;
   ctl_type            rd_ctl;
   ctl_type            red_ctl;
   logic [FIELD_W-1:0] red_op;
   logic [FIELD_W-1:0] red_prod;
   logic [FIELD_W-1:0] rd_data;
   logic [FIELD_W-1:0] old_acc;
   logic [FIELD_W-1:0] new_acc;

   logic [PARTIES-1:0] valid_ff;
   logic [PARTIES-1:0] valid_in;
   logic               byp_hit_ff;
   logic               byp_hit_in;
   logic [FIELD_W-1:0] byp_data_ff;

   logic                  strobe_ff;
   logic [PARTY_IN_W-1:0] party_ff;
   logic [FIELD_W-1:0]    acc_ff;

   assign busy = reset;

   always_comb begin
      in_ctl.vld = start && !busy;
      in_ctl.cmd = cmd_type'(req_command);
      in_ctl.idx = wrap_party(req_party);
   end

   gfmac_mul_pipe u_mul_pipe (
      .clock    (clock),
      .reset    (reset),
      .in_ctl   (in_ctl),
      .in_op    ({req_operand_high, req_operand_low}),
      .in_mult  ({req_mult_high, req_mult_low}),
      .rd_ctl   (rd_ctl),
      .red_ctl  (red_ctl),
      .red_op   (red_op),
      .red_prod (red_prod)
   );

   gfmac_ram #(.WIDTH(HALF_W), .DEPTH(PARTIES)) u_acc_low_ram (
      .clock   (clock),
      .wr_en   (red_ctl.vld),
      .wr_addr (red_ctl.idx),
      .wr_data (new_acc[HALF_W-1:0]),
      .rd_addr (rd_ctl.idx),
      .rd_data (rd_data[HALF_W-1:0])
   );

   gfmac_ram #(.WIDTH(HALF_W), .DEPTH(PARTIES)) u_acc_high_ram (
      .clock   (clock),
      .wr_en   (red_ctl.vld),
      .wr_addr (red_ctl.idx),
      .wr_data (new_acc[FIELD_W-1:HALF_W]),
      .rd_addr (rd_ctl.idx),
      .rd_data (rd_data[FIELD_W-1:HALF_W])
   );

   // The RAM returns old data when the entry is written in the cycle of the read.
   assign byp_hit_in = red_ctl.vld && (red_ctl.idx == rd_ctl.idx);

   always_comb begin
      if (byp_hit_ff) begin
         old_acc = byp_data_ff;
      end else if (valid_ff[red_ctl.idx]) begin
         old_acc = rd_data;
      end else begin
         old_acc = '0;
      end
      unique case (red_ctl.cmd)
         CMD_LOAD: new_acc = red_op;
         CMD_MAC:  new_acc = old_acc ^ red_prod;
         default:  new_acc = old_acc ^ red_prod;
      endcase
      valid_in = valid_ff;
      if (red_ctl.vld) begin
         valid_in[red_ctl.idx] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff   <= '0;
         byp_hit_ff <= 1'b0;
         strobe_ff  <= 1'b0;
      end else begin
         valid_ff   <= valid_in;
         byp_hit_ff <= byp_hit_in;
         strobe_ff  <= red_ctl.vld;
      end
   end

   always_ff @(posedge clock) begin
      byp_data_ff <= new_acc;
      party_ff    <= PARTY_IN_W'(red_ctl.idx);
      acc_ff      <= new_acc;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_out_party    = party_ff;
   assign rsp_acc_out_low  = acc_ff[HALF_W-1:0];
   assign rsp_acc_out_high = acc_ff[FIELD_W-1:HALF_W];

endmodule

`default_nettype wire

### src/gfmac_checker.sv
// Port-level checks for the multiply-accumulate block, bound to its top level.
`default_nettype none

module gfmac_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                start,
   input wire logic                                busy,
   input wire logic                                req_command,
   input wire logic [gfmac_pkg::PARTY_IN_W-1:0]    req_party,
   input wire logic [gfmac_pkg::HALF_W-1:0]        req_operand_low,
   input wire logic [gfmac_pkg::HALF_W-1:0]        req_operand_high,
   input wire logic                                rsp_strobe,
   input wire logic [gfmac_pkg::PARTY_IN_W-1:0]    rsp_out_party,
   input wire logic [gfmac_pkg::HALF_W-1:0]        rsp_acc_out_low,
   input wire logic [gfmac_pkg::HALF_W-1:0]        rsp_acc_out_high
);

   import gfmac_pkg::*;

   logic accept;
   logic load_cmd;

   assign accept   = start && !busy;
   assign load_cmd = (req_command == CMD_LOAD);

   // Every accepted transaction is followed by its response strobe.
   a_rsp_follows_req: assert property (@(posedge clock) disable iff (reset)
      accept |-> ##LATENCY rsp_strobe)
      else $error("response missing after accepted transaction");

   // No response appears without a transaction behind it.
   a_no_spurious_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(accept, LATENCY))
      else $error("response without a matching transaction");

   // The response names the wrapped party of its transaction.
   a_rsp_party: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_out_party == PARTY_IN_W'(wrap_party($past(req_party, LATENCY)))))
      else $error("response party does not match transaction");

   // A load reports the operand as the new accumulator, whatever was in flight.
   a_load_value: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && $past(load_cmd, LATENCY)) |->
         (rsp_acc_out_low == $past(req_operand_low, LATENCY)) &&
         (rsp_acc_out_high == $past(req_operand_high, LATENCY)))
      else $error("load response differs from loaded operand");

endmodule

bind gf128_multiply_accumulate gfmac_checker u_gfmac_checker (.*);

`default_nettype wire

### sim/tb_gf128_multiply_accumulate.sv
// Self-checking testbench for the per-party GF(2^128) multiply-accumulate block.
`timescale 1ns / 1ps

module tb_gf128_multiply_accumulate;

   import gfmac_pkg::*;

   localparam logic [7:0] FIELD_TAIL   = 8'h87;
   localparam int         RANDOM_ITEMS = 1250;
   localparam int         IDLE_PERCENT = 35;

   typedef struct {
      cmd_type               command;
      logic [PARTY_IN_W-1:0] party;
      logic [FIELD_W-1:0]    operand;
      logic [FIELD_W-1:0]    multiplier;
   } mac_request_type;

   typedef struct {
      logic [PARTY_IN_W-1:0] party;
      logic [FIELD_W-1:0]    acc;
   } acc_report_type;

   logic                  clock            = 1'b0;
   logic                  reset            = 1'b1;
   logic                  start            = 1'b0;
   logic                  busy;
   logic                  req_command      = 1'b0;
   logic [PARTY_IN_W-1:0] req_party        = '0;
   logic [HALF_W-1:0]     req_operand_low  = '0;
   logic [HALF_W-1:0]     req_operand_high = '0;
   logic [HALF_W-1:0]     req_mult_low     = '0;
   logic [HALF_W-1:0]     req_mult_high    = '0;
   logic                  rsp_strobe;
   logic [PARTY_IN_W-1:0] rsp_out_party;
   logic [HALF_W-1:0]     rsp_acc_out_low;
   logic [HALF_W-1:0]     rsp_acc_out_high;

   mac_request_type pending_requests[$];
   acc_report_type  expected_accumulators[$];
   logic [FIELD_W-1:0] party_acc [PARTIES];
   mac_request_type current_request;
   acc_report_type  observed_report;
   int  accepted_count = 0;
   int  error_count    = 0;
   logic hold_off;

   gf128_multiply_accumulate dut (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_command      (req_command),
      .req_party        (req_party),
      .req_operand_low  (req_operand_low),
      .req_operand_high (req_operand_high),
      .req_mult_low     (req_mult_low),
      .req_mult_high    (req_mult_high),
      .rsp_strobe       (rsp_strobe),
      .rsp_out_party    (rsp_out_party),
      .rsp_acc_out_low  (rsp_acc_out_low),
      .rsp_acc_out_high (rsp_acc_out_high)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Full schoolbook product, then the overflow bits are cleared one at a time from the
   // top, using x^128 = x^7 + x^2 + x + 1.
   function automatic logic [FIELD_W-1:0] gf128_product(input logic [FIELD_W-1:0] a,
                                                        input logic [FIELD_W-1:0] b);
      logic [2*FIELD_W-1:0] wide;
      wide = '0;
      for (int i = 0; i < FIELD_W; i++) begin
         if (b[i]) begin
            wide = wide ^ ({{FIELD_W{1'b0}}, a} << i);
         end
      end
      for (int i = 2 * FIELD_W - 2; i >= FIELD_W; i--) begin
         if (wide[i]) begin
            wide[i] = 1'b0;
            wide    = wide ^ ((2*FIELD_W)'(FIELD_TAIL) << (i - FIELD_W));
         end
      end
      return wide[FIELD_W-1:0];
   endfunction

   function automatic void update_accumulator(input mac_request_type r);
      int             slot;
      acc_report_type report;
      slot = int'(r.party) % PARTIES;
      if (r.command == CMD_LOAD) begin
         party_acc[slot] = r.operand;
      end else begin
         party_acc[slot] = party_acc[slot] ^ gf128_product(r.operand, r.multiplier);
      end
      report.party = PARTY_IN_W'(slot);
      report.acc   = party_acc[slot];
      expected_accumulators.push_back(report);
   endfunction

   function automatic void queue_request(input cmd_type command,
                                         input logic [PARTY_IN_W-1:0] party,
                                         input logic [FIELD_W-1:0] operand,
                                         input logic [FIELD_W-1:0] multiplier);
      mac_request_type r;
      r.command    = command;
      r.party      = party;
      r.operand    = operand;
      r.multiplier = multiplier;
      pending_requests.push_back(r);
   endfunction

   // Mostly dense random polynomials, with zero, all ones and single terms mixed in.
   function automatic logic [FIELD_W-1:0] pick_field_value();
      int roll;
      roll = $urandom_range(99);
      if (roll < 8) begin
         return '0;
      end else if (roll < 16) begin
         return '1;
      end else if (roll < 28) begin
         return FIELD_W'(1) << $urandom_range(FIELD_W - 1);
      end
      return {$urandom, $urandom, $urandom, $urandom};
   endfunction

   function automatic void check_field(input string label, input logic [HALF_W-1:0] want,
                                       input logic [HALF_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch: expected %h, actual %h", $time, label, want, got);
         error_count++;
      end
   endfunction

   // Driver: a transaction is accepted at an edge with start high and busy low.
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy) begin
            update_accumulator(current_request);
            accepted_count++;
         end
         // The directed items and one long stretch in the middle go back to back.
         hold_off = !(accepted_count < 30 || (accepted_count >= 600 && accepted_count < 900))
                    && ($urandom_range(99) < IDLE_PERCENT);
         if (start && busy) begin
            // Keep the current transaction on the ports until it is taken.
         end else if (pending_requests.size() != 0 && !hold_off) begin
            current_request = pending_requests.pop_front();
            start            <= 1'b1;
            req_command      <= current_request.command;
            req_party        <= current_request.party;
            req_operand_low  <= current_request.operand[HALF_W-1:0];
            req_operand_high <= current_request.operand[FIELD_W-1:HALF_W];
            req_mult_low     <= current_request.multiplier[HALF_W-1:0];
            req_mult_high    <= current_request.multiplier[FIELD_W-1:HALF_W];
         end else begin
            start <= 1'b0;
         end
      end
   end

   // Monitor: every strobe is one result and must match the oldest prediction.
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (expected_accumulators.size() == 0) begin
            $display("%0t: unexpected result: party %0d, accumulator %h_%h", $time,
                     rsp_out_party, rsp_acc_out_high, rsp_acc_out_low);
            error_count++;
         end else begin
            observed_report = expected_accumulators.pop_front();
            check_field("party", HALF_W'(observed_report.party), HALF_W'(rsp_out_party));
            check_field("acc_low", observed_report.acc[HALF_W-1:0], rsp_acc_out_low);
            check_field("acc_high", observed_report.acc[FIELD_W-1:HALF_W], rsp_acc_out_high);
         end
      end
   end

   initial begin : stimulus
      logic [PARTY_IN_W-1:0] party;
      logic [PARTY_IN_W-1:0] last_party;
      cmd_type               command;
      int                    roll;

      foreach (party_acc[i]) begin
         party_acc[i] = '0;
      end

      // An accumulator untouched since reset reads as zero.
      queue_request(CMD_MAC, 4'd3, '0, '0);
      // Load ignores the multiplier.
      queue_request(CMD_LOAD, 4'd0, '1, '1);
      queue_request(CMD_MAC, 4'd0, '1, '1);
      // Highest-degree product needs both folding steps.
      queue_request(CMD_MAC, 4'd0, FIELD_W'(1) << 127, FIELD_W'(1) << 127);
      queue_request(CMD_MAC, 4'd0, FIELD_W'(1) << 127, FIELD_W'(2));
      queue_request(CMD_LOAD, 4'd15, pick_field_value(), {$urandom, $urandom, $urandom, $urandom});
      queue_request(CMD_MAC, 4'd15, {$urandom, $urandom, $urandom, $urandom}, FIELD_W'(1));
      queue_request(CMD_MAC, 4'd15, {$urandom, $urandom, $urandom, $urandom}, '0);
      queue_request(CMD_MAC, 4'd15, {{HALF_W{1'b1}}, {HALF_W{1'b0}}},
                    {{HALF_W{1'b1}}, {HALF_W{1'b0}}});
      queue_request(CMD_MAC, 4'd15, {{HALF_W{1'b0}}, {HALF_W{1'b1}}},
                    {{HALF_W{1'b1}}, {HALF_W{1'b0}}});
      queue_request(CMD_LOAD, 4'd7, '0, '1);
      // Back-to-back updates of one party exercise the read forwarding.
      for (int i = 0; i < 5; i++) begin
         queue_request(CMD_MAC, 4'd7, {$urandom, $urandom, $urandom, $urandom},
                       {$urandom, $urandom, $urandom, $urandom});
      end
      queue_request(CMD_LOAD, 4'd7, {$urandom, $urandom, $urandom, $urandom}, '0);
      queue_request(CMD_MAC, 4'd7, '1, {$urandom, $urandom, $urandom, $urandom});
      queue_request(CMD_MAC, 4'd1, {$urandom, $urandom, $urandom, $urandom}, '1);
      queue_request(CMD_MAC, 4'd8, {$urandom, $urandom, $urandom, $urandom},
                    {$urandom, $urandom, $urandom, $urandom});
      queue_request(CMD_MAC, 4'd14, '1, FIELD_W'(1) << 64);

      // Random part: a few hot parties and frequent repeats keep the forwarding busy.
      last_party = 4'd0;
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         roll = $urandom_range(99);
         if (roll < 40) begin
            party = last_party;
         end else if (roll < 70) begin
            party = PARTY_IN_W'($urandom_range(3));
         end else begin
            party = PARTY_IN_W'($urandom_range(15));
         end
         command = ($urandom_range(99) < 15) ? CMD_LOAD : CMD_MAC;
         queue_request(command, party, pick_field_value(), pick_field_value());
         last_party = party;
      end

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      while (pending_requests.size() != 0 || start) @(posedge clock);
      while (expected_accumulators.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);

      if (error_count == 0 && expected_accumulators.size() == 0) begin
         $display("gf128_multiply_accumulate regression: pass");
      end else begin
         $display("gf128_multiply_accumulate regression: fail");
      end
      $finish;
   end

   initial begin
      #3_000_000;
      $display("gf128_multiply_accumulate regression: fail");
      $finish;
   end

endmodule
